// File: design/lrra_pkg.sv
// Shared types, constants and helper functions of the LED ring ripple animator.
package lrra_pkg;

    // Ring geometry
    localparam int RING_PIXELS = 16;
    localparam int HALF_RING   = RING_PIXELS / 2;
    localparam int MEM_DEPTH   = 2 * RING_PIXELS;
    localparam int PIX_W       = (RING_PIXELS > 1) ? $clog2(RING_PIXELS) : 1;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int CNT_W       = $clog2(RING_PIXELS + 1);
    localparam int DIST_W      = $clog2(HALF_RING + 1);

    // Field widths
    localparam int LEVEL_W   = 8;
    localparam int DROP_W    = 4;
    localparam int WAIT_W    = 4;
    localparam int IDX_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0]  CNT_N     = CNT_W'(RING_PIXELS);
    localparam logic [PIX_W-1:0]  PIX_LAST  = PIX_W'(RING_PIXELS - 1);
    localparam logic [DIST_W-1:0] DIST_LAST = DIST_W'(HALF_RING);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INCREMENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_DROP_OFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DROP_OFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_DELAY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_DELAY    = 3'd5;

    // Configuration reset values
    localparam logic [LEVEL_W-1:0] RST_STEP_INCREMENT = 8'd20;
    localparam logic [LEVEL_W-1:0] RST_PEAK_LEVEL     = 8'd100;
    localparam logic [LEVEL_W-1:0] RST_RING_DROP_OFF  = 8'd5;
    localparam logic [LEVEL_W-1:0] RST_PEAK_DROP_OFF  = 8'd15;
    localparam logic [LEVEL_W-1:0] RST_SPREAD_DELAY   = 8'd3;
    localparam logic [LEVEL_W-1:0] RST_PAUSE_DELAY    = 8'd3;

    typedef enum logic [1:0] {
        HEAD_IDLE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } heading_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] step_increment;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] ring_drop_off;
        logic [LEVEL_W-1:0] peak_drop_off;
        logic [LEVEL_W-1:0] spread_delay;
        logic [LEVEL_W-1:0] pause_delay;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        heading_t           heading;
        logic [LEVEL_W-1:0] hold;
        logic [LEVEL_W-1:0] ceiling;
    } pixel_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        pixel_t            wr_data;
    } ram_req_t;

    // Drop position reduced into the ring, one entry per possible drop value
    function automatic logic [15:0][PIX_W-1:0] make_drop_wrap();
        logic [15:0][PIX_W-1:0] t;
        for (int i = 0; i < 16; i++)
        begin
            t[i] = PIX_W'(i % RING_PIXELS);
        end
        return t;
    endfunction

    localparam logic [15:0][PIX_W-1:0] DROP_WRAP = make_drop_wrap();

    // Memory address of a pixel of a ring
    function automatic logic [ADDR_W-1:0] pix_addr(input logic lens, input logic [PIX_W-1:0] p);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(p);
        if (lens)
        begin
            a = a + ADDR_W'(RING_PIXELS);
        end
        return a;
    endfunction

    function automatic logic [PIX_W-1:0] pix_inc(input logic [PIX_W-1:0] p);
        return (p == PIX_LAST) ? '0 : p + PIX_W'(1);
    endfunction

    function automatic logic [PIX_W-1:0] pix_dec(input logic [PIX_W-1:0] p);
        return (p == '0) ? PIX_LAST : p - PIX_W'(1);
    endfunction

    function automatic logic [LEVEL_W-1:0] sat_add(input logic [LEVEL_W-1:0] a,
                                                   input logic [LEVEL_W-1:0] b);
        logic [LEVEL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEVEL_W] ? {LEVEL_W{1'b1}} : s[LEVEL_W-1:0];
    endfunction

endpackage

// File: design/lrra_pixel_ram.sv
// Pixel state memory: one write port, one registered read port, per-entry valid bits.
module lrra_pixel_ram (
    input  logic               clk,
    input  logic               rst_n,
    input  lrra_pkg::ram_req_t req,
    output lrra_pkg::pixel_t   rd_data
);
    import lrra_pkg::*;

    pixel_t                 mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]   valid_reg;
    pixel_t                 q_reg;
    logic                   q_valid_reg;

    // Store write data and read word
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg <= mem[req.rd_addr];
        end
    end

    // Track written entries; an unwritten entry reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                q_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

// File: design/lrra_advance_unit.sv
// Shared per-pixel update unit: one animation tick of one pixel.
module lrra_advance_unit (
    input  lrra_pkg::cfg_t   cfg,
    input  lrra_pkg::pixel_t cur,
    output lrra_pkg::pixel_t nxt
);
    import lrra_pkg::*;

    logic [LEVEL_W:0] up_sum;

    assign up_sum = {1'b0, cur.level} + {1'b0, cfg.step_increment};

    // Count down the hold, else ramp toward the ceiling or back to zero
    always_comb
    begin
        nxt = cur;
        if (cur.hold != '0)
        begin
            nxt.hold = cur.hold - LEVEL_W'(1);
        end
        else
        begin
            case (cur.heading)
                HEAD_UP:
                begin
                    if (up_sum <= {1'b0, cur.ceiling})
                    begin
                        nxt.level = up_sum[LEVEL_W-1:0];
                    end
                    else if (cur.ceiling > cfg.peak_drop_off)
                    begin
                        nxt.level   = cur.ceiling;
                        nxt.ceiling = cur.ceiling - cfg.peak_drop_off;
                        nxt.heading = HEAD_DOWN;
                    end
                    else
                    begin
                        nxt.level   = '0;
                        nxt.ceiling = '0;
                        nxt.heading = HEAD_IDLE;
                    end
                end
                HEAD_DOWN:
                begin
                    if (cur.level < cfg.step_increment)
                    begin
                        nxt.level   = '0;
                        nxt.heading = HEAD_UP;
                        nxt.hold    = cfg.pause_delay;
                    end
                    else
                    begin
                        nxt.level = cur.level - cfg.step_increment;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

// File: design/lrra_sequencer.sv
// Tick sequencer: dark scan, drop seeding and pixel update over the shared memory port.
module lrra_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_lens,
    input  logic [lrra_pkg::DROP_W-1:0]   in_drop,
    input  logic [lrra_pkg::WAIT_W-1:0]   in_draw,
    input  lrra_pkg::cfg_t                cfg,
    output lrra_pkg::ram_req_t            ram_req,
    input  lrra_pkg::pixel_t              rd_data,
    input  lrra_pkg::pixel_t              adv_nxt,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lrra_pkg::IDX_W-1:0]    out_index,
    output logic [lrra_pkg::LEVEL_W-1:0]  out_level,
    output logic                          out_last
);
    import lrra_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SEED,
        S_UPDATE
    } state_t;

    state_t                        state_reg, state_next;
    logic                          lens_reg, lens_next;
    logic [PIX_W-1:0]              drop_reg, drop_next;
    logic [WAIT_W-1:0]             draw_reg, draw_next;
    logic [1:0][WAIT_W-1:0]        wait_reg, wait_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          have_reg, have_next;
    logic                          dark_reg, dark_next;
    logic [DIST_W-1:0]             dist_reg, dist_next;
    logic                          side_reg, side_next;
    logic [PIX_W-1:0]              left_reg, left_next;
    logic [PIX_W-1:0]              right_reg, right_next;
    logic [LEVEL_W-1:0]            dl_reg, dl_next;
    logic [LEVEL_W-1:0]            off_reg, off_next;
    logic                          out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]              out_index_reg, out_index_next;
    logic [LEVEL_W-1:0]            out_level_reg, out_level_next;
    logic                          out_last_reg, out_last_next;

    logic                          dark_now;
    logic                          consume;
    logic [CNT_W-1:0]              emit_cnt;
    logic [PIX_W-1:0]              emit_pix;
    pixel_t                        seed_word;

    assign dark_now = dark_reg & (rd_data.level == '0);
    assign emit_cnt = cnt_reg - CNT_W'(1);
    assign emit_pix = emit_cnt[PIX_W-1:0];
    assign consume  = (state_reg == S_UPDATE) && have_reg && (!out_valid_reg || out_ready);

    // Neighbor seed word at the current distance
    always_comb
    begin
        seed_word.level   = '0;
        seed_word.heading = HEAD_UP;
        seed_word.hold    = dl_reg;
        seed_word.ceiling = (off_reg >= cfg.peak_level) ? '0 : cfg.peak_level - off_reg;
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        lens_next      = lens_reg;
        drop_next      = drop_reg;
        draw_next      = draw_reg;
        wait_next      = wait_reg;
        cnt_next       = cnt_reg;
        have_next      = have_reg;
        dark_next      = dark_reg;
        dist_next      = dist_reg;
        side_next      = side_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        dl_next        = dl_reg;
        off_next       = off_reg;
        out_index_next = out_index_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;
        ram_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lens_next  = in_lens;
                    drop_next  = DROP_WRAP[in_drop];
                    draw_next  = in_draw;
                    cnt_next   = '0;
                    have_next  = 1'b0;
                    dark_next  = 1'b1;
                    state_next = S_SCAN;
                end
            end

            // Read every pixel of the ring and check for any lit one
            S_SCAN:
            begin
                if (cnt_reg < CNT_N)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = pix_addr(lens_reg, cnt_reg[PIX_W-1:0]);
                    cnt_next        = cnt_reg + CNT_W'(1);
                end
                have_next = (cnt_reg < CNT_N);
                if (have_reg)
                begin
                    dark_next = dark_now;
                end
                if ((cnt_reg == CNT_N) && have_reg)
                begin
                    cnt_next   = '0;
                    have_next  = 1'b0;
                    state_next = S_UPDATE;
                    if (dark_now)
                    begin
                        if (wait_reg[lens_reg] == '0)
                        begin
                            wait_next[lens_reg] = draw_reg;
                            dist_next           = '0;
                            side_next           = 1'b0;
                            dl_next             = '0;
                            off_next            = '0;
                            state_next          = S_SEED;
                        end
                        else
                        begin
                            wait_next[lens_reg] = wait_reg[lens_reg] - WAIT_W'(1);
                        end
                    end
                end
            end

            // Write the drop pixel, then left and right neighbors per distance
            S_SEED:
            begin
                ram_req.wr_en = 1'b1;
                if (dist_reg == '0)
                begin
                    ram_req.wr_addr         = pix_addr(lens_reg, drop_reg);
                    ram_req.wr_data.level   = LEVEL_W'(1);
                    ram_req.wr_data.heading = HEAD_UP;
                    ram_req.wr_data.hold    = '0;
                    ram_req.wr_data.ceiling = cfg.peak_level;
                    dist_next  = DIST_W'(1);
                    dl_next    = sat_add(dl_reg, cfg.spread_delay);
                    off_next   = sat_add(off_reg, cfg.ring_drop_off);
                    left_next  = pix_dec(drop_reg);
                    right_next = pix_inc(drop_reg);
                end
                else if (!side_reg)
                begin
                    ram_req.wr_addr = pix_addr(lens_reg, left_reg);
                    ram_req.wr_data = seed_word;
                    side_next       = 1'b1;
                end
                else
                begin
                    ram_req.wr_addr = pix_addr(lens_reg, right_reg);
                    ram_req.wr_data = seed_word;
                    side_next       = 1'b0;
                    if (dist_reg == DIST_LAST)
                    begin
                        cnt_next   = '0;
                        have_next  = 1'b0;
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        dist_next  = dist_reg + DIST_W'(1);
                        dl_next    = sat_add(dl_reg, cfg.spread_delay);
                        off_next   = sat_add(off_reg, cfg.ring_drop_off);
                        left_next  = pix_dec(left_reg);
                        right_next = pix_inc(right_reg);
                    end
                end
            end

            // Read ahead, advance the pixel, write it back and present it
            S_UPDATE:
            begin
                if ((cnt_reg < CNT_N) && (!have_reg || consume))
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = pix_addr(lens_reg, cnt_reg[PIX_W-1:0]);
                    cnt_next        = cnt_reg + CNT_W'(1);
                    have_next       = 1'b1;
                end
                else if (consume)
                begin
                    have_next = 1'b0;
                end
                if (consume)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = pix_addr(lens_reg, emit_pix);
                    ram_req.wr_data = adv_nxt;
                    out_index_next  = IDX_W'(pix_addr(lens_reg, emit_pix));
                    out_level_next  = adv_nxt.level;
                    out_last_next   = (emit_pix == PIX_LAST);
                    if (emit_pix == PIX_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Hold the result until its transfer
        if (consume)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lens_reg      <= 1'b0;
            drop_reg      <= '0;
            draw_reg      <= '0;
            wait_reg      <= '0;
            cnt_reg       <= '0;
            have_reg      <= 1'b0;
            dark_reg      <= 1'b0;
            dist_reg      <= '0;
            side_reg      <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            dl_reg        <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_level_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lens_reg      <= lens_next;
            drop_reg      <= drop_next;
            draw_reg      <= draw_next;
            wait_reg      <= wait_next;
            cnt_reg       <= cnt_next;
            have_reg      <= have_next;
            dark_reg      <= dark_next;
            dist_reg      <= dist_next;
            side_reg      <= side_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            dl_reg        <= dl_next;
            off_reg       <= off_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_level_reg <= out_level_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_level = out_level_reg;
    assign out_last  = out_last_reg;

endmodule

// File: design/led_ring_ripple_animator_core.sv
// Top level of the LED ring ripple animator: stream ports, configuration registers, core.
//
// Each input transfer is one animation tick for one of two rings of RING_PIXELS pixels;
// the block answers with one output transfer per pixel of that ring, in pixel order,
// tlast on the final one. All pixel state lives in one memory with a single read and a
// single write port, and a small sequencer walks it pixel by pixel through one shared
// update unit. A tick runs a dark scan of the ring, then, when a new drop starts, the
// seeding writes of the drop and its neighbors, then the pixel update, which stalls while
// the output is not taken. No input is taken while a tick is in progress. Configuration
// is written through the cfg channel, which is always ready; indexes beyond the register
// list are ignored.
module led_ring_ripple_animator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input ticks
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // drop_position[3:0], wait_draw[7:4]
    input  logic [0:0]                         s_axis_tuser,   // lens[0]
    // Pixel levels
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,   // pixel_index[4:0], pixel_level[12:5]
    output logic                               m_axis_tlast,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lrra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrra_pkg::LEVEL_W-1:0]       cfg_data
);
    import lrra_pkg::*;

    cfg_t                cfg_reg;
    ram_req_t            ram_req;
    pixel_t              rd_data;
    pixel_t              adv_nxt;
    logic [IDX_W-1:0]    out_index;
    logic [LEVEL_W-1:0]  out_level;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_increment <= RST_STEP_INCREMENT;
            cfg_reg.peak_level     <= RST_PEAK_LEVEL;
            cfg_reg.ring_drop_off  <= RST_RING_DROP_OFF;
            cfg_reg.peak_drop_off  <= RST_PEAK_DROP_OFF;
            cfg_reg.spread_delay   <= RST_SPREAD_DELAY;
            cfg_reg.pause_delay    <= RST_PAUSE_DELAY;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STEP_INCREMENT: cfg_reg.step_increment <= cfg_data;
                CFG_PEAK_LEVEL:     cfg_reg.peak_level     <= cfg_data;
                CFG_RING_DROP_OFF:  cfg_reg.ring_drop_off  <= cfg_data;
                CFG_PEAK_DROP_OFF:  cfg_reg.peak_drop_off  <= cfg_data;
                CFG_SPREAD_DELAY:   cfg_reg.spread_delay   <= cfg_data;
                CFG_PAUSE_DELAY:    cfg_reg.pause_delay    <= cfg_data;
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    lrra_pixel_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    lrra_advance_unit u_advance (
        .cfg (cfg_reg),
        .cur (rd_data),
        .nxt (adv_nxt)
    );

    lrra_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_lens   (s_axis_tuser[0]),
        .in_drop   (s_axis_tdata[3:0]),
        .in_draw   (s_axis_tdata[7:4]),
        .cfg       (cfg_reg),
        .ram_req   (ram_req),
        .rd_data   (rd_data),
        .adv_nxt   (adv_nxt),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (out_index),
        .out_level (out_level),
        .out_last  (m_axis_tlast)
    );

    // Pack the result
    assign m_axis_tdata = {3'b000, out_level, out_index};

    // A tick runs alone: no second input right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a tick is in progress");

    // Between ticks only the final pixel of the last tick may still wait
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tready && m_axis_tvalid) |-> m_axis_tlast)
        else $error("pending pixel is not the last of its tick at idle");

    // Pixel memory is never written between ticks
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.wr_en |-> !s_axis_tready)
        else $error("pixel memory written while idle");

endmodule

// File: tb/tb_led_ring_ripple_animator_core.sv
// Self-checking testbench of the LED ring ripple animator core with a built-in tick predictor.
module tb_led_ring_ripple_animator_core;
    import lrra_pkg::*;

    // Indexes past the register list, written to prove they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int IDLE_PCT      = 29;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_TICKS   = 41;
    localparam int STEADY_PHASE  = 3;
    localparam int DRAIN_CYCLES  = 60;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic               lens;
        logic [DROP_W-1:0]  drop;
        logic [WAIT_W-1:0]  draw;
    } tick_t;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } pixel_out_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // drop_position[3:0], wait_draw[7:4]
    logic [0:0]           s_axis_tuser  = '0;   // lens[0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;         // pixel_index[4:0], pixel_level[12:5]
    logic                 m_axis_tlast;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [LEVEL_W-1:0]   cfg_data      = '0;

    // Predicted ring state and register copy
    logic [LEVEL_W-1:0]   pix_level   [MEM_DEPTH];
    heading_t             pix_heading [MEM_DEPTH];
    logic [LEVEL_W-1:0]   pix_hold    [MEM_DEPTH];
    logic [LEVEL_W-1:0]   pix_ceiling [MEM_DEPTH];
    logic [WAIT_W-1:0]    ring_wait   [2];
    cfg_t                 regs;

    tick_t                tick_pending [$];
    pixel_out_t           pixel_expect [$];
    tick_t                drive_tick;
    pixel_out_t           got_pixel;
    pixel_out_t           want_pixel;

    logic                 no_gaps      = 1'b0;
    int                   mismatches   = 0;
    int                   ticks_taken  = 0;
    int                   pixels_seen  = 0;
    int                   drops_seeded = 0;
    int                   reg_writes   = 0;
    int                   cycle_count  = 0;

    led_ring_ripple_animator_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Seed a new drop: all headings up, ceilings and start delays by ring distance
    function automatic void seed_drop(int base, int drop);
        int          left;
        int          right;
        int unsigned span;
        int unsigned cut;
        for (int p = 0; p < RING_PIXELS; p++)
        begin
            pix_heading[base + p] = HEAD_UP;
        end
        pix_hold[base + drop]    = '0;
        pix_ceiling[base + drop] = regs.peak_level;
        pix_level[base + drop]   = 8'd1;
        for (int d = 1; d <= HALF_RING; d++)
        begin
            left  = (drop + 2 * RING_PIXELS - d) % RING_PIXELS;
            right = (drop + d) % RING_PIXELS;
            span  = d * int'(regs.spread_delay);
            cut   = d * int'(regs.ring_drop_off);
            pix_hold[base + left]  = (span > 255) ? 8'd255 : span[7:0];
            pix_hold[base + right] = pix_hold[base + left];
            pix_ceiling[base + left] = (cut >= int'(regs.peak_level)) ?
                                       '0 : LEVEL_W'(int'(regs.peak_level) - cut);
            pix_ceiling[base + right] = pix_ceiling[base + left];
        end
    endfunction

    // Advance one pixel by one tick
    function automatic void ramp_pixel(int k);
        int unsigned next;
        if (pix_hold[k] != 0)
        begin
            pix_hold[k] = pix_hold[k] - 1'b1;
            return;
        end
        case (pix_heading[k])
            HEAD_UP:
            begin
                next = int'(pix_level[k]) + int'(regs.step_increment);
                if (next <= int'(pix_ceiling[k]))
                begin
                    pix_level[k] = next[7:0];
                end
                else if (pix_ceiling[k] > regs.peak_drop_off)
                begin
                    pix_level[k]   = pix_ceiling[k];
                    pix_ceiling[k] = pix_ceiling[k] - regs.peak_drop_off;
                    pix_heading[k] = HEAD_DOWN;
                end
                else
                begin
                    pix_ceiling[k] = '0;
                    pix_level[k]   = '0;
                    pix_heading[k] = HEAD_IDLE;
                end
            end
            HEAD_DOWN:
            begin
                if (pix_level[k] < regs.step_increment)
                begin
                    pix_heading[k] = HEAD_UP;
                    pix_level[k]   = '0;
                    pix_hold[k]    = regs.pause_delay;
                end
                else
                begin
                    pix_level[k] = pix_level[k] - regs.step_increment;
                end
            end
            default: ;
        endcase
    endfunction

    // Predict the pixel levels that one tick produces and queue them
    function automatic void predict_tick(tick_t t);
        int         base;
        int         drop;
        logic       dark;
        pixel_out_t e;
        base = t.lens ? RING_PIXELS : 0;
        drop = int'(t.drop) % RING_PIXELS;
        dark = 1'b1;
        for (int p = 0; p < RING_PIXELS; p++)
        begin
            if (pix_level[base + p] != 0)
            begin
                dark = 1'b0;
            end
        end
        if (dark)
        begin
            if (ring_wait[t.lens] == 0)
            begin
                seed_drop(base, drop);
                ring_wait[t.lens] = t.draw;
                drops_seeded++;
            end
            else
            begin
                ring_wait[t.lens] = ring_wait[t.lens] - 1'b1;
            end
        end
        for (int p = 0; p < RING_PIXELS; p++)
        begin
            ramp_pixel(base + p);
            e.index = IDX_W'(base + p);
            e.level = pix_level[base + p];
            e.last  = (p == RING_PIXELS - 1);
            pixel_expect.push_back(e);
        end
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
        case (idx)
            CFG_STEP_INCREMENT: regs.step_increment = val;
            CFG_PEAK_LEVEL:     regs.peak_level     = val;
            CFG_RING_DROP_OFF:  regs.ring_drop_off  = val;
            CFG_PEAK_DROP_OFF:  regs.peak_drop_off  = val;
            CFG_SPREAD_DELAY:   regs.spread_delay   = val;
            CFG_PAUSE_DELAY:    regs.pause_delay    = val;
            default: ;
        endcase
    endfunction

    function automatic void queue_tick(logic lens, logic [DROP_W-1:0] drop,
                                       logic [WAIT_W-1:0] draw);
        tick_t t;
        t.lens = lens;
        t.drop = drop;
        t.draw = draw;
        tick_pending.push_back(t);
    endfunction

    // Drive tick transfers from the pending queue, with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (tick_pending.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                drive_tick = tick_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {drive_tick.draw, drive_tick.drop};
                s_axis_tuser  <= drive_tick.lens;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Stall the pixel stream at random
    always @(posedge clk)
    begin
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Check pixel transfers, then predict accepted ticks and track register writes
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            pixels_seen++;
            got_pixel.index = m_axis_tdata[IDX_W-1:0];
            got_pixel.level = m_axis_tdata[IDX_W +: LEVEL_W];
            got_pixel.last  = m_axis_tlast;
            if (pixel_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("unexpected pixel transfer: index %0d level %0d last %0b",
                             got_pixel.index, got_pixel.level, got_pixel.last);
                end
            end
            else
            begin
                want_pixel = pixel_expect.pop_front();
                if (got_pixel.index !== want_pixel.index || got_pixel.level !== want_pixel.level
                    || got_pixel.last !== want_pixel.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display({"pixel mismatch: expected index %0d level %0d last %0b,",
                                  " got index %0d level %0d last %0b"},
                                 want_pixel.index, want_pixel.level, want_pixel.last,
                                 got_pixel.index, got_pixel.level, got_pixel.last);
                    end
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            drive_tick_predict: begin
                ticks_taken++;
                predict_tick(tick_t'{s_axis_tuser[0], s_axis_tdata[3:0], s_axis_tdata[7:4]});
            end
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            reg_writes++;
            apply_reg(cfg_index, cfg_data);
        end
    end

    // Write one register through the cfg channel
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(logic [LEVEL_W-1:0] step, logic [LEVEL_W-1:0] peak,
                                  logic [LEVEL_W-1:0] ring_off, logic [LEVEL_W-1:0] peak_off,
                                  logic [LEVEL_W-1:0] spread, logic [LEVEL_W-1:0] pause);
        write_reg(CFG_STEP_INCREMENT, step);
        write_reg(CFG_PEAK_LEVEL, peak);
        write_reg(CFG_RING_DROP_OFF, ring_off);
        write_reg(CFG_PEAK_DROP_OFF, peak_off);
        write_reg(CFG_SPREAD_DELAY, spread);
        write_reg(CFG_PAUSE_DELAY, pause);
    endtask

    // Hold until every tick is taken and every pixel has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (tick_pending.size() != 0 || s_axis_tvalid || pixel_expect.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Timeout guard
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("timeout after %0d cycles, %0d pixels still pending",
                 cycle_count, pixel_expect.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        for (int k = 0; k < MEM_DEPTH; k++)
        begin
            pix_level[k]   = '0;
            pix_heading[k] = HEAD_IDLE;
            pix_hold[k]    = '0;
            pix_ceiling[k] = '0;
        end
        ring_wait[0] = '0;
        ring_wait[1] = '0;
        regs = '{step_increment: RST_STEP_INCREMENT, peak_level: RST_PEAK_LEVEL,
                 ring_drop_off: RST_RING_DROP_OFF, peak_drop_off: RST_PEAK_DROP_OFF,
                 spread_delay: RST_SPREAD_DELAY, pause_delay: RST_PAUSE_DELAY};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: drops at both ends of the index range, longest and shortest waits
        queue_tick(1'b0, 4'd0, 4'd15);
        queue_tick(1'b1, 4'd15, 4'd0);
        queue_tick(1'b1, 4'd7, 4'd0);
        queue_tick(1'b0, 4'd15, 4'd0);
        for (int i = 0; i < 8; i++)
        begin
            queue_tick(1'b1, 4'd8, 4'd0);
        end
        wait_idle();

        // Top of every register range, plus writes to unused indexes
        write_all_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        write_reg(CFG_SPARE_6, 8'd0);
        write_reg(CFG_SPARE_7, 8'd1);
        queue_tick(1'b0, 4'd0, 4'd0);
        queue_tick(1'b1, 4'd15, 4'd15);
        queue_tick(1'b0, 4'd9, 4'd0);
        queue_tick(1'b0, 4'd3, 4'd0);
        queue_tick(1'b0, 4'd12, 4'd0);
        wait_idle();

        // Bottom of every register range: a drop finishes on its first ceiling
        write_all_regs(8'd1, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0);
        queue_tick(1'b0, 4'd5, 4'd0);
        queue_tick(1'b0, 4'd10, 4'd0);
        queue_tick(1'b0, 4'd10, 4'd0);
        queue_tick(1'b1, 4'd2, 4'd0);
        queue_tick(1'b0, 4'd14, 4'd0);
        queue_tick(1'b1, 4'd1, 4'd0);

        // Random phases, each with its own register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            no_gaps = (ph == STEADY_PHASE);
            if (ph % 3 == 2)
            begin
                write_all_regs(LEVEL_W'($urandom_range(1, 255)),
                               LEVEL_W'($urandom_range(1, 255)),
                               LEVEL_W'($urandom_range(0, 255)),
                               LEVEL_W'($urandom_range(1, 255)),
                               LEVEL_W'($urandom_range(0, 255)),
                               LEVEL_W'($urandom_range(0, 255)));
            end
            else
            begin
                write_all_regs(LEVEL_W'($urandom_range(8, 80)),
                               LEVEL_W'($urandom_range(20, 255)),
                               LEVEL_W'($urandom_range(0, 30)),
                               LEVEL_W'($urandom_range(1, 60)),
                               LEVEL_W'($urandom_range(0, 3)),
                               LEVEL_W'($urandom_range(0, 4)));
            end
            // Mostly short waits so that drops keep starting
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                queue_tick(1'($urandom_range(0, 1)), DROP_W'($urandom_range(0, 15)),
                           ($urandom_range(0, 99) < 70) ? WAIT_W'($urandom_range(0, 2))
                                                        : WAIT_W'($urandom_range(0, 15)));
            end
        end

        wait_idle();
        no_gaps = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d ticks on both rings, %0d pixel transfers, %0d drop starts",
                 ticks_taken, pixels_seen, drops_seeded);
        $display("register writes: %0d over %0d settings, extremes and unused indexes included",
                 reg_writes, RANDOM_PHASES + 2);
        if (mismatches == 0 && pixel_expect.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
